// ----- hw/rtl/sorted_key_record_table_top_defines.svh -----
// Assertion macros shared by the sorted key record table RTL.
// Users must have clk and arst_n in scope where the macros expand.
`ifndef SORTED_KEY_RECORD_TABLE_TOP_DEFINES_SVH
`define SORTED_KEY_RECORD_TABLE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKRT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/skrt_pkg.sv -----
// Package for the sorted key record table: field widths, request and status codes,
// beat and record types, and the controller state type. No dependencies.
package skrt_pkg;

	localparam int KEY_W = 31;
	localparam int NAME_W = 64;
	localparam int YEAR_W = 12;
	localparam int COUNT_W = 6;
	localparam int DEFAULT_DEPTH = 32;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_ABSENT = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [KEY_W-1:0] key;
		logic [NAME_W-1:0] name_tag;
		logic [YEAR_W-1:0] entry_year;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [NAME_W-1:0] found_name;
		logic [YEAR_W-1:0] found_year;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [NAME_W-1:0] name_tag;
		logic [YEAR_W-1:0] entry_year;
	} rec_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_PLACE
	} state_t;

endpackage

// ----- hw/rtl/skrt_ram.sv -----
// Record memory of the sorted key record table: one write port, one read port,
// registered read data. Depends on skrt_pkg for the record type.
module skrt_ram #(
	parameter int DEPTH = skrt_pkg::DEFAULT_DEPTH
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  skrt_pkg::rec_t           wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output skrt_pkg::rec_t           rd_data
);
	import skrt_pkg::*;

	rec_t mem_q [DEPTH];
	rec_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/sorted_key_record_table_top.sv -----
// Insert, remove and lookup walk the record memory one entry per cycle through its
// single read port, and busy stays high for the whole walk. Full-table inserts, remove
// and lookup on an empty table and the unused code finish without a walk, and an insert
// into an empty table goes straight to placing the record; the next request is taken
// in the done cycle.
// Reset clears the count and control state only, with no clearing pass.
module sorted_key_record_table_top #(
	parameter int TABLE_DEPTH = skrt_pkg::DEFAULT_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  skrt_pkg::req_t req,
	output logic           done,
	output skrt_pkg::rsp_t rsp
);
	import skrt_pkg::*;
	`include "sorted_key_record_table_top_defines.svh"

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t state_q, state_d;
	req_t req_q, req_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [AW-1:0] place_q, place_d;
	logic issue_q, issue_d;
	logic found_q, found_d;
	logic rd_v_s1;
	logic [AW-1:0] rd_idx_s1;
	logic done_q, done_d;
	rsp_t rsp_q, rsp_d;

	logic wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr, last_idx;
	rec_t wr_data, rd_data;
	logic fin, match;
	logic [1:0] fin_status;
	logic [NAME_W-1:0] fin_name;
	logic [YEAR_W-1:0] fin_year;

	skrt_ram #(
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign last_idx = AW'(cnt_q - CW'(1));
	assign match = (rd_data.key == req_q.key);

	always_comb begin
		state_d = state_q;
		req_d = req_q;
		cnt_d = cnt_q;
		ptr_d = ptr_q;
		place_d = place_q;
		issue_d = issue_q;
		found_d = found_q;
		rsp_d = rsp_q;
		done_d = 1'b0;
		wr_en = 1'b0;
		wr_addr = place_q;
		wr_data = rd_data;
		rd_en = 1'b0;
		rd_addr = ptr_q;
		fin = 1'b0;
		fin_status = STAT_OK;
		fin_name = '0;
		fin_year = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_d = req;
					found_d = 1'b0;
					case (req.req_type)
						REQ_INSERT: begin
							if (cnt_q >= CW'(TABLE_DEPTH)) begin
								fin = 1'b1;
								fin_status = STAT_FULL;
							end else if (cnt_q == '0) begin
								place_d = '0;
								state_d = S_PLACE;
							end else begin
								ptr_d = last_idx;
								issue_d = 1'b1;
								state_d = S_SCAN;
							end
						end
						REQ_REMOVE, REQ_LOOKUP: begin
							if (cnt_q == '0) begin
								fin = 1'b1;
								fin_status = STAT_ABSENT;
							end else begin
								ptr_d = '0;
								issue_d = 1'b1;
								state_d = S_SCAN;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				rd_en = issue_q;
				if (issue_q) begin
					if (req_q.req_type == REQ_INSERT) begin
						if (ptr_q == '0) begin
							issue_d = 1'b0;
						end else begin
							ptr_d = ptr_q - AW'(1);
						end
					end else begin
						if (ptr_q == last_idx) begin
							issue_d = 1'b0;
						end else begin
							ptr_d = ptr_q + AW'(1);
						end
					end
				end
				if (rd_v_s1) begin
					case (req_q.req_type)
						REQ_INSERT: begin
							issue_d = 1'b0;
							state_d = S_PLACE;
							if (rd_data.key > req_q.key) begin
								wr_en = 1'b1;
								wr_addr = rd_idx_s1 + AW'(1);
								place_d = '0;
								if (rd_idx_s1 != '0) begin
									issue_d = 1'b1;
									state_d = S_SCAN;
								end
							end else begin
								place_d = rd_idx_s1 + AW'(1);
							end
						end
						REQ_REMOVE: begin
							if (found_q) begin
								wr_en = 1'b1;
								wr_addr = rd_idx_s1 - AW'(1);
							end else if (match) begin
								found_d = 1'b1;
							end
							if (rd_idx_s1 == last_idx) begin
								fin = 1'b1;
								if (found_q || match) begin
									cnt_d = cnt_q - CW'(1);
								end else begin
									fin_status = STAT_ABSENT;
								end
							end
						end
						default: begin
							if (match) begin
								fin = 1'b1;
								fin_name = rd_data.name_tag;
								fin_year = rd_data.entry_year;
							end else if (rd_idx_s1 == last_idx) begin
								fin = 1'b1;
								fin_status = STAT_ABSENT;
							end
						end
					endcase
				end
			end
			S_PLACE: begin
				wr_en = 1'b1;
				wr_addr = place_q;
				wr_data = '{key: req_q.key, name_tag: req_q.name_tag,
					entry_year: req_q.entry_year};
				cnt_d = cnt_q + CW'(1);
				fin = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = S_IDLE;
			issue_d = 1'b0;
			done_d = 1'b1;
			rsp_d.status = fin_status;
			rsp_d.found_name = fin_name;
			rsp_d.found_year = fin_year;
			rsp_d.entry_count = COUNT_W'(cnt_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			issue_q <= 1'b0;
			found_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			issue_q <= issue_d;
			found_q <= found_d;
			rd_v_s1 <= rd_en;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q <= req_d;
		ptr_q <= ptr_d;
		place_q <= place_d;
		rd_idx_s1 <= rd_addr;
		rsp_q <= rsp_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;

	`SKRT_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CW'(TABLE_DEPTH), "record count above depth")
	`SKRT_ASSERT_SAME(a_wr_in_range, wr_en, CW'(wr_addr) <= cnt_q, "write beyond stored records")
	`SKRT_ASSERT_SAME(a_full_only_when_full, done && (rsp.status == STAT_FULL),
		cnt_q == CW'(TABLE_DEPTH), "full status while table has room")
	`SKRT_ASSERT_SAME(a_miss_zero, done && (rsp.status != STAT_OK),
		(rsp.found_name == '0) && (rsp.found_year == '0), "payload on a miss")
	`SKRT_ASSERT_NEXT(a_done_ends_busy, done_d, !busy, "busy after the result beat")

endmodule
